// ===== hdl/bitonic_sort_network_tagged_defines.svh =====
// Assertion macros used by the sorter's top-level RTL file.
`ifndef BITONIC_SORT_NETWORK_TAGGED_DEFINES_SVH
`define BITONIC_SORT_NETWORK_TAGGED_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define BSNT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define BSNT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bsnt_pkg.sv =====
// Shared types, constants and helper functions of the tagged bitonic sorter.
package bsnt_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int MAX_LOG      = IDX_W;
	localparam int LOG_W        = 3;
	localparam int PASS_W       = $clog2(MAX_LOG);
	localparam int VAL_W        = 32;
	localparam int TAG_W        = 32;
	localparam int DATA_W       = VAL_W + TAG_W;
	localparam int FIFO_DEPTH   = 4;
	localparam int FPTR_W       = $clog2(FIFO_DEPTH);
	localparam int FCNT_W       = FPTR_W + 1;
	localparam logic [LOG_W-1:0] SIZE_LOG_RESET = LOG_W'(4);

	typedef struct packed {
		logic [TAG_W-1:0]        tag;
		logic signed [VAL_W-1:0] value;
	} elem_t;

	typedef struct packed {
		elem_t elem;
		logic  last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic             run_open;
		logic [IDX_W-1:0] fill;
	} front_stat_t;

	typedef struct packed {
		logic loading;
		logic sorting;
		logic emitting;
	} back_stat_t;

	// Clamp the size register into 1..MAX_LOG.
	function automatic logic [LOG_W-1:0] eff_log(input logic [LOG_W-1:0] cfg);
		logic [LOG_W-1:0] r;
		r = cfg;
		if (cfg == '0)
			r = LOG_W'(1);
		else if (cfg > LOG_W'(MAX_LOG))
			r = LOG_W'(MAX_LOG);
		return r;
	endfunction

	// Index of the final element of a run of 2^lg elements.
	function automatic logic [IDX_W-1:0] last_idx_of(input logic [LOG_W-1:0] lg);
		logic [CNT_W-1:0] n;
		n = (CNT_W'(1) << lg) - CNT_W'(1);
		return n[IDX_W-1:0];
	endfunction

	// log2 of the run length, from the index of its final element (2^lg - 1).
	function automatic logic [LOG_W-1:0] log_of_last(input logic [IDX_W-1:0] idx);
		logic [LOG_W-1:0] r;
		r = '0;
		for (int b = 0; b < IDX_W; b++)
			r = r + LOG_W'(idx[b]);
		return r;
	endfunction

endpackage

// ===== hdl/bsnt_front.sv =====
// Input side: holds the size register, counts elements and marks the end of each run.
module bsnt_front
	import bsnt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	output logic              push,
	output item_t             push_item,
	input  fifo_stat_t        fifo_stat,
	output front_stat_t       stat
);

	logic [LOG_W-1:0] size_log_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] run_last;
	logic             is_last;

	assign run_last = last_idx_of(eff_log(size_log_q));
	assign is_last  = (fill_q == run_last);
	assign s_tready = !fifo_stat.full;
	assign push     = s_tvalid && s_tready;

	assign push_item.elem.value = s_tdata[VAL_W-1:0];
	assign push_item.elem.tag   = s_tdata[DATA_W-1:VAL_W];
	assign push_item.last       = is_last;

	assign stat.run_open = (fill_q != '0);
	assign stat.fill     = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log_q <= SIZE_LOG_RESET;
			fill_q     <= '0;
		end else if (cfg_we) begin
			// drop any partial run
			size_log_q <= cfg_wdata;
			fill_q     <= '0;
		end else if (push) begin
			fill_q <= is_last ? '0 : fill_q + IDX_W'(1);
		end
	end

endmodule

// ===== hdl/bsnt_fifo.sv =====
// Short item queue between the input side and the sort engine.
module bsnt_fifo
	import bsnt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  item_t      push_item,
	input  logic       pop,
	output item_t      pop_item,
	output fifo_stat_t stat
);

	item_t             mem [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_q;
	logic [FPTR_W-1:0] rd_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == FCNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_item   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + FPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + FPTR_W'(1);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + FCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/bsnt_back.sv =====
// Sort engine: loads a run, applies one comparator layer per cycle, then streams it out.
module bsnt_back
	import bsnt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	output logic              pop,
	input  item_t             pop_item,
	input  fifo_stat_t        fifo_stat,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast,
	output back_stat_t        stat
);

	typedef enum logic [1:0] {ST_LOAD, ST_SORT, ST_EMIT} state_t;

	state_t            state_q;
	elem_t             store [MAX_ELEMENTS];
	elem_t             net [MAX_ELEMENTS];
	logic [IDX_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic [LOG_W-1:0]  size_log_q;
	logic [LOG_W-1:0]  s_q;
	logic [PASS_W-1:0] p_q;
	logic              out_valid_q;
	elem_t             out_elem_q;
	logic              out_last_q;
	logic              flip;
	logic [IDX_W-1:0]  mask;
	logic              advance;

	assign pop     = (state_q == ST_LOAD) && !fifo_stat.empty;
	assign advance = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_elem_q.tag, out_elem_q.value};
	assign m_tlast  = out_last_q;

	assign stat.loading  = (state_q == ST_LOAD);
	assign stat.sorting  = (state_q == ST_SORT);
	assign stat.emitting = (state_q == ST_EMIT);

	// Flip layer pairs i with i ^ (2^s - 1); half-cleaner pairs i with i ^ 2^p.
	assign flip = (s_q == LOG_W'(p_q) + LOG_W'(1));
	assign mask = flip ? ((IDX_W'(1) << s_q) - IDX_W'(1)) : (IDX_W'(1) << p_q);

	always_comb begin
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] j;
		logic             lo;
		logic             swap;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			idx  = IDX_W'(i);
			j    = idx ^ mask;
			lo   = !idx[p_q];
			swap = lo ? (store[j].value > store[i].value)
			          : (store[i].value > store[j].value);
			net[i] = swap ? store[j] : store[i];
		end
	end

	// Element store: write on load, whole-array update on sort, shift on emit.
	always_ff @(posedge clk) begin
		if (pop) begin
			store[cnt_q] <= pop_item.elem;
		end else if (state_q == ST_SORT) begin
			store <= net;
		end else if (advance) begin
			for (int i = 0; i < MAX_ELEMENTS - 1; i++)
				store[i] <= store[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			last_idx_q  <= '0;
			size_log_q  <= '0;
			s_q         <= '0;
			p_q         <= '0;
			out_valid_q <= 1'b0;
			out_elem_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (m_tready && !advance)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_we) begin
						// drop the partial run along with the size change
						cnt_q <= '0;
					end else if (pop) begin
						cnt_q <= cnt_q + IDX_W'(1);
						if (pop_item.last) begin
							last_idx_q <= cnt_q;
							size_log_q <= log_of_last(cnt_q);
							s_q        <= LOG_W'(1);
							p_q        <= '0;
							state_q    <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					if (p_q == '0) begin
						if (s_q == size_log_q) begin
							cnt_q   <= '0;
							state_q <= ST_EMIT;
						end else begin
							p_q <= s_q[PASS_W-1:0];
							s_q <= s_q + LOG_W'(1);
						end
					end else begin
						p_q <= p_q - PASS_W'(1);
					end
				end
				ST_EMIT: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						out_elem_q  <= store[0];
						out_last_q  <= (cnt_q == last_idx_q);
						if (cnt_q == last_idx_q) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

// ===== hdl/bitonic_sort_network_tagged.sv =====
// Top level of the tagged bitonic sorter: input side, item queue and sort engine.
//
//  channel  | direction | handshake          | payload (lowest bit first)
//  ---------+-----------+--------------------+---------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: value[31:0], tag[63:32]
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: value_res[31:0], tag_res[63:32];
//           |           |                    | m_tlast: last element of the sorted run
//  cfg_*    | in        | cfg_we             | cfg_wdata: sort_size_log2[2:0]
//
// A run of n = 2^L elements (L = sort_size_log2 clamped to 1..4) is loaded into the
// sort engine, sorted one comparator layer at a time and then emitted; the engine's
// single element store means it takes one run at a time.
// The input side keeps taking items into a four-entry queue while the engine sorts or
// emits, so the next run starts filling without waiting.
// Reset (arst_n low, asynchronous) clears the counters, the queue and the output valid,
// and sets sort_size_log2 to 4; the element store is left as is.
// The output register holds an item while m_tready is low; the engine waits on it.
`include "bitonic_sort_network_tagged_defines.svh"

module bitonic_sort_network_tagged
	import bsnt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG_W-1:0]  cfg_wdata,   // sort_size_log2
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,     // value[31:0], tag[63:32]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,     // value_res[31:0], tag_res[63:32]
	output logic              m_tlast
);

	logic        push;
	item_t       push_item;
	logic        pop;
	item_t       pop_item;
	fifo_stat_t  fifo_stat;
	front_stat_t front_stat;
	back_stat_t  back_stat;

	// Count and classify incoming items.
	bsnt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.fifo_stat (fifo_stat),
		.stat      (front_stat)
	);

	// Decouple the input side from the sort engine.
	bsnt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (fifo_stat)
	);

	// Load, sort and emit one run at a time; a size write drops a partly loaded run.
	bsnt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.pop       (pop),
		.pop_item  (pop_item),
		.fifo_stat (fifo_stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.stat      (back_stat)
	);

	// The engine never drains the queue while sorting or emitting.
	`BSNT_ASSERT_SAME(a_no_pop_busy, clk, arst_n, back_stat.sorting || back_stat.emitting, !pop, "queue popped while the engine was busy")
	// A full queue is never empty at the same time.
	`BSNT_ASSERT_SAME(a_fifo_flags, clk, arst_n, fifo_stat.full, !fifo_stat.empty, "queue flags inconsistent")
	// A size write restarts the run count.
	`BSNT_ASSERT_NEXT(a_cfg_clears, clk, arst_n, cfg_we, !front_stat.run_open, "run count not cleared by size write")

endmodule

// ===== test/bsnt_sort_monitor.sv =====
// Monitor for the tagged bitonic sorter: predicts each sorted run and checks every result.
`timescale 1ns / 100ps

module bsnt_sort_monitor
	import bsnt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,     // value[31:0], tag[63:32]
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,     // value_res[31:0], tag_res[63:32]
	input  logic              m_tlast,
	output int                fail_count,
	output int                pending,
	output int                results_seen,
	output int                runs_seen
);

	logic [LOG_W-1:0] size_log;
	int               filled;
	int               run_n;
	elem_t            gathered [MAX_ELEMENTS];
	item_t            sorted_q [$];
	item_t            want;
	elem_t            got;

	initial begin
		fail_count   = 0;
		pending      = 0;
		results_seen = 0;
		runs_seen    = 0;
	end

	function automatic int run_len(input logic [LOG_W-1:0] lg);
		int n;
		n = (lg == '0) ? 2 : (1 << lg);
		while (n > MAX_ELEMENTS)
			n = n >> 1;
		return n;
	endfunction

	// Exchange i < j only when key j is strictly greater; equal keys stay put.
	function void order_pair(input int i, input int j);
		elem_t t;
		if ($signed(gathered[j].value) > $signed(gathered[i].value)) begin
			t           = gathered[i];
			gathered[i] = gathered[j];
			gathered[j] = t;
		end
	endfunction

	// Flip comparators per block, then half-cleaners down to distance 1.
	function void sort_gathered(input int n);
		for (int k = 2; k <= n; k = k << 1) begin
			for (int b = 0; b < n; b += k)
				for (int i = 0; i < k / 2; i++)
					order_pair(b + i, b + k - 1 - i);
			for (int d = k / 4; d >= 1; d = d >> 1)
				for (int b = 0; b < n; b += 2 * d)
					for (int i = 0; i < d; i++)
						order_pair(b + i, b + i + d);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log = SIZE_LOG_RESET;
			filled   = 0;
			sorted_q.delete();
			pending  = 0;
		end else begin
			// A size write drops whatever part of a run was collected.
			if (cfg_we) begin
				size_log = cfg_wdata;
				filled   = 0;
			end
			if (s_tvalid && s_tready) begin
				run_n = run_len(size_log);
				if (filled >= run_n)
					filled = 0;
				gathered[filled] = s_tdata;
				filled++;
				if (filled == run_n) begin
					sort_gathered(run_n);
					for (int k = 0; k < run_n; k++)
						sorted_q.push_back('{elem: gathered[k], last: (k == run_n - 1)});
					filled = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (sorted_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected: value %0d tag %h last %b",
						$time, $signed(got.value), got.tag, m_tlast);
				end else begin
					want = sorted_q.pop_front();
					if (got.value !== want.elem.value) begin
						fail_count++;
						$display("%0t: value_res expected %0d actual %0d", $time,
							$signed(want.elem.value), $signed(got.value));
					end
					if (got.tag !== want.elem.tag) begin
						fail_count++;
						$display("%0t: tag_res expected %h actual %h", $time,
							want.elem.tag, got.tag);
					end
					if (m_tlast !== want.last) begin
						fail_count++;
						$display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
					end
				end
				results_seen++;
				if (m_tlast === 1'b1)
					runs_seen++;
			end
			pending = sorted_q.size();
		end
	end

endmodule

// ===== test/bitonic_sort_network_tagged_tb.sv =====
// Testbench top for the tagged bitonic sorter: stimulus, idling, back-pressure and verdict.
`timescale 1ns / 100ps

module bitonic_sort_network_tagged_tb;
	import bsnt_pkg::*;

	// Margin after each phase for a 16-element run to pass the engine and the item queue.
	localparam int SETTLE      = 64;
	localparam int HOLD_CYCLES = 240;
	localparam int ITEM_GOAL   = 420;

	// Extremes, duplicates of both ends and a block of equal keys with distinct tags.
	localparam logic [31:0] EDGE_KEYS [16] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0005,
		32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0000,
		32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
	};
	localparam logic [31:0] EDGE_TAGS [16] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
		32'h0000_0004, 32'h0000_0005, 32'h0000_0006, 32'h0000_0007,
		32'h0000_0008, 32'h0000_0009, 32'h0000_000A, 32'h0000_000B,
		32'h0000_000C, 32'h0000_000D, 32'h0000_000E, 32'h0000_000F
	};
	// First random phases sweep every size code, out-of-range ones included.
	localparam logic [LOG_W-1:0] SIZE_SWEEP [8] = '{
		3'd0, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7, 3'd1, 3'd4
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [LOG_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;

	logic calm;       // no idling on either side while set
	logic hold_req;   // ask the receiver for one long hold-off
	int   items_sent;
	int   phases;
	int   fail_count;
	int   pending;
	int   results_seen;
	int   runs_seen;

	bitonic_sort_network_tagged dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	bsnt_sort_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.runs_seen   (runs_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("bitonic_sort_network_tagged: mismatch");
		$finish;
	end

	// Receiver: stall at random about 17 percent of the time, never while calm, and once hold
	// off for a long stretch so the engine and the item queue fill and s_tready drops.
	initial begin
		int  stall;
		bit  hold_taken;
		stall      = 0;
		hold_taken = 0;
		m_tready   = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				stall      = HOLD_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 17);
			end
		end
	end

	// Mostly full-range keys, with extremes and a narrow band that forces ties.
	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		case ($urandom_range(0, 9))
			0: k = 32'h7FFF_FFFF;
			1: k = 32'h8000_0000;
			2, 3, 4: k = 32'($urandom_range(0, 6)) - 32'd3;
			default: k = $urandom;
		endcase
		return k;
	endfunction

	// Present one item, idling first at random, and hold it until accepted.
	task automatic offer(input logic [31:0] key, input logic [31:0] tag);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 17)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {tag, key};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	// Drop valid, wait until every predicted result is out, then idle for the SETTLE margin
	// before the next size write; a partial run waits in the engine until that write drops it.
	task automatic settle();
		int waited;
		waited   = 0;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_size(input logic [LOG_W-1:0] lg);
		cfg_we    <= 1'b1;
		cfg_wdata <= lg;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [LOG_W-1:0] lg;
		int               n;
		int               runs;
		int               tail;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		items_sent = 0;
		phases     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size is 16: one run of extremes, ties and both sign ends.
		for (int i = 0; i < 16; i++)
			offer(EDGE_KEYS[i], EDGE_TAGS[i]);
		settle();

		// Pairs: equal keys must keep their order, a larger second key must swap.
		set_size(3'd1);
		offer(32'd3, 32'h0000_0001);
		offer(32'd3, 32'h0000_0002);
		offer(-32'sd7, 32'h0000_0003);
		offer(32'd9, 32'h0000_0004);
		settle();

		// Start an 8-element run and abandon it; the next size write drops it.
		set_size(3'd3);
		repeat (3) offer(pick_key(), $urandom);
		settle();

		// Back-pressure: the receiver holds off while three full runs are offered.
		set_size(3'd4);
		hold_req <= 1'b1;
		repeat (48) offer(pick_key(), $urandom);
		settle();

		// Random phases: whole runs with random content, sometimes a dangling tail.
		while (items_sent < ITEM_GOAL) begin
			lg = (phases < 8) ? SIZE_SWEEP[phases] : LOG_W'($urandom_range(0, 7));
			calm <= (phases >= 3 && phases <= 5);
			set_size(lg);
			n    = (lg == '0) ? 2 : (lg > LOG_W'(MAX_LOG)) ? MAX_ELEMENTS : (1 << lg);
			runs = $urandom_range(1, (n >= MAX_ELEMENTS) ? 2 : 5);
			repeat (runs * n) offer(pick_key(), $urandom);
			if ($urandom_range(0, 2) == 0) begin
				tail = $urandom_range(1, n - 1);
				repeat (tail) offer(pick_key(), $urandom);
			end
			settle();
			phases++;
		end
		calm <= 1'b0;

		$display("Run covered %0d items over %0d random phases, every size code 0..7,",
			items_sent, phases);
		$display("abandoned partial runs and one long output hold-off; %0d runs, %0d results.",
			runs_seen, results_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("bitonic_sort_network_tagged: match");
		end else begin
			$display("bitonic_sort_network_tagged: mismatch");
		end
		$finish;
	end

endmodule
